### design/sliding_median_spike_detector_top_defines.svh
// Assertion macros shared by the checker of the spike detector.
`ifndef SLIDING_MEDIAN_SPIKE_DETECTOR_TOP_DEFINES_SVH
`define SLIDING_MEDIAN_SPIKE_DETECTOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMSD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/smsd_pkg.sv
package smsd_pkg;

  localparam int WINDOW_MAX = 256;
  localparam int VALUE_BITS = 16;
  localparam int IDX_BITS   = $clog2(WINDOW_MAX);
  localparam int LEN_BITS   = $clog2(WINDOW_MAX + 1);
  localparam int CFG_BITS   = 9;
  localparam int COUNT_BITS = 24;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [CFG_BITS-1:0]   LEN_RESET = CFG_BITS'(5);

  typedef struct packed {
    logic                  re;
    logic [IDX_BITS-1:0]   raddr;
    logic                  we;
    logic [IDX_BITS-1:0]   waddr;
    logic [VALUE_BITS-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] a;
    logic [VALUE_BITS-1:0] b0;
    logic [VALUE_BITS-1:0] b1;
  } cmp_req_t;

  typedef struct packed {
    logic ge;
    logic eq;
  } cmp_rsp_t;

endpackage

### design/sliding_median_spike_detector_top.sv
// Sliding-window median spike detector.
// Samples arrive on the input channel (amount_i, start_new_i) with valid and ready;
// each input transaction produces exactly one result transaction (notice_o,
// notice_count_o, window_ready_o) on the output channel. The window length is
// written through its own valid/ready channel, which empties the window.
// One sample is handled at a time by a sequencer around a single adder-comparator
// and a sorted store with one read and one write port. With the window full, a
// sample is handled in steps: read the median, remove the oldest value, insert
// the new one, then finish. While the window fills, the median read and the
// removal are skipped.
// After reset the window length is 5, the window is empty and the notice count is
// zero; the stores need no clearing. If the receiver stalls, the result waits in the
// output register and the block stops in its last step until that register is free.
module sliding_median_spike_detector_top import smsd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_BITS-1:0]   window_len_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] amount_i,
  input  logic                  start_new_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  notice_o,
  output logic [COUNT_BITS-1:0] notice_count_o,
  output logic                  window_ready_o
);

  mem_req_t              sort_req;
  mem_req_t              ring_req;
  logic [VALUE_BITS-1:0] sort_rdata;
  logic [VALUE_BITS-1:0] ring_rdata;
  cmp_req_t              cmp_req;
  cmp_rsp_t              cmp_rsp;

  smsd_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .window_len_i   (window_len_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .amount_i       (amount_i),
    .start_new_i    (start_new_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .notice_o       (notice_o),
    .notice_count_o (notice_count_o),
    .window_ready_o (window_ready_o),
    .sort_req_o     (sort_req),
    .sort_rdata_i   (sort_rdata),
    .ring_req_o     (ring_req),
    .ring_rdata_i   (ring_rdata),
    .cmp_req_o      (cmp_req),
    .cmp_rsp_i      (cmp_rsp)
  );

  smsd_cmp u_cmp (
    .req_i (cmp_req),
    .rsp_o (cmp_rsp)
  );

  smsd_ram u_sorted (
    .clk_i   (clk_i),
    .req_i   (sort_req),
    .rdata_o (sort_rdata)
  );

  smsd_ram u_ring (
    .clk_i   (clk_i),
    .req_i   (ring_req),
    .rdata_o (ring_rdata)
  );

endmodule

### design/smsd_ram.sv
module smsd_ram import smsd_pkg::*; (
  input  logic                  clk_i,
  input  mem_req_t              req_i,
  output logic [VALUE_BITS-1:0] rdata_o
);

  logic [VALUE_BITS-1:0] mem_q [WINDOW_MAX];
  logic [VALUE_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/smsd_cmp.sv
module smsd_cmp import smsd_pkg::*; (
  input  cmp_req_t req_i,
  output cmp_rsp_t rsp_o
);

  logic [VALUE_BITS:0] sum;
  logic [VALUE_BITS:0] lhs;

  assign sum      = {1'b0, req_i.b0} + {1'b0, req_i.b1};
  assign lhs      = {1'b0, req_i.a};
  assign rsp_o.ge = (lhs >= sum);
  assign rsp_o.eq = (lhs == sum);

endmodule

### design/smsd_ctrl.sv
module smsd_ctrl import smsd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_BITS-1:0]   window_len_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] amount_i,
  input  logic                  start_new_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  notice_o,
  output logic [COUNT_BITS-1:0] notice_count_o,
  output logic                  window_ready_o,
  output mem_req_t              sort_req_o,
  input  logic [VALUE_BITS-1:0] sort_rdata_i,
  output mem_req_t              ring_req_o,
  input  logic [VALUE_BITS-1:0] ring_rdata_i,
  output cmp_req_t              cmp_req_o,
  input  cmp_rsp_t              cmp_rsp_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MED_LO,
    ST_MED_HI,
    ST_MED_CMP,
    ST_REMOVE,
    ST_INSERT,
    ST_PLACE,
    ST_FINISH
  } state_e;

  state_e                state_q, state_d;
  logic [CFG_BITS-1:0]   wlen_q, wlen_d;
  logic [LEN_BITS-1:0]   len_q, len_d;
  logic [LEN_BITS-1:0]   fill_q, fill_d;
  logic [IDX_BITS-1:0]   ptr_q, ptr_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] amount_q, amount_d;
  logic                  ready_q, ready_d;
  logic                  notice_q, notice_d;
  logic [VALUE_BITS-1:0] med_lo_q, med_lo_d;
  logic [LEN_BITS-1:0]   pass_k_q, pass_k_d;
  logic [LEN_BITS-1:0]   n_q, n_d;
  logic                  found_q, found_d;
  logic                  placed_q, placed_d;
  logic [VALUE_BITS-1:0] carry_q, carry_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_notice_q, out_notice_d;
  logic [COUNT_BITS-1:0] out_count_q, out_count_d;
  logic                  out_ready_q, out_ready_d;

  logic [LEN_BITS-1:0]   len_c;
  logic [LEN_BITS-1:0]   fill_s, fill_c;
  logic [IDX_BITS-1:0]   ptr_s, ptr_c;
  logic                  ready_c;
  logic [IDX_BITS-1:0]   half_idx, lo_idx;
  logic [LEN_BITS-1:0]   k_m1, k_m2, ptr_inc;

  always_comb begin
    if (wlen_q == '0) begin
      len_c = LEN_BITS'(1);
    end else if (32'(wlen_q) > 32'(WINDOW_MAX)) begin
      len_c = LEN_BITS'(WINDOW_MAX);
    end else begin
      len_c = LEN_BITS'(wlen_q);
    end
  end

  assign fill_s   = start_new_i ? '0 : fill_q;
  assign ptr_s    = start_new_i ? '0 : ptr_q;
  assign fill_c   = (fill_s > len_c) ? len_c : fill_s;
  assign ptr_c    = (LEN_BITS'(ptr_s) >= len_c) ? '0 : ptr_s;
  assign ready_c  = (fill_c == len_c);
  assign half_idx = IDX_BITS'(len_q >> 1);
  assign lo_idx   = len_q[0] ? half_idx : half_idx - IDX_BITS'(1);
  assign k_m1     = pass_k_q - LEN_BITS'(1);
  assign k_m2     = pass_k_q - LEN_BITS'(2);
  assign ptr_inc  = LEN_BITS'(ptr_q) + LEN_BITS'(1);

  assign cfg_ready_o    = (state_q == ST_IDLE);
  assign in_ready_o     = (state_q == ST_IDLE) && !cfg_valid_i;
  assign out_valid_o    = out_valid_q;
  assign notice_o       = out_notice_q;
  assign notice_count_o = out_count_q;
  assign window_ready_o = out_ready_q;

  always_comb begin
    state_d      = state_q;
    wlen_d       = wlen_q;
    len_d        = len_q;
    fill_d       = fill_q;
    ptr_d        = ptr_q;
    cnt_d        = cnt_q;
    amount_d     = amount_q;
    ready_d      = ready_q;
    notice_d     = notice_q;
    med_lo_d     = med_lo_q;
    pass_k_d     = pass_k_q;
    n_d          = n_q;
    found_d      = found_q;
    placed_d     = placed_q;
    carry_d      = carry_q;
    out_valid_d  = out_valid_q;
    out_notice_d = out_notice_q;
    out_count_d  = out_count_q;
    out_ready_d  = out_ready_q;
    sort_req_o   = '0;
    ring_req_o   = '0;
    cmp_req_o.a  = amount_q;
    cmp_req_o.b0 = sort_rdata_i;
    cmp_req_o.b1 = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_valid_i) begin
          wlen_d = window_len_i;
          fill_d = '0;
          ptr_d  = '0;
        end else if (in_valid_i) begin
          amount_d = amount_i;
          len_d    = len_c;
          fill_d   = fill_c;
          ptr_d    = ptr_c;
          ready_d  = ready_c;
          notice_d = 1'b0;
          pass_k_d = '0;
          found_d  = 1'b0;
          placed_d = 1'b0;
          if (start_new_i) begin
            cnt_d = '0;
          end
          if (ready_c) begin
            state_d = ST_MED_LO;
          end else begin
            n_d     = fill_c;
            state_d = ST_INSERT;
          end
        end
      end
      ST_MED_LO: begin
        sort_req_o.re    = 1'b1;
        sort_req_o.raddr = lo_idx;
        ring_req_o.re    = 1'b1;
        ring_req_o.raddr = ptr_q;
        state_d          = ST_MED_HI;
      end
      ST_MED_HI: begin
        sort_req_o.re    = 1'b1;
        sort_req_o.raddr = half_idx;
        med_lo_d         = sort_rdata_i;
        state_d          = ST_MED_CMP;
      end
      ST_MED_CMP: begin
        cmp_req_o.b1 = med_lo_q;
        notice_d     = cmp_rsp_i.ge;
        if (cmp_rsp_i.ge && (cnt_q != COUNT_MAX)) begin
          cnt_d = cnt_q + COUNT_BITS'(1);
        end
        n_d     = len_q;
        state_d = ST_REMOVE;
      end
      ST_REMOVE: begin
        cmp_req_o.a      = ring_rdata_i;
        sort_req_o.re    = (pass_k_q < n_q);
        sort_req_o.raddr = pass_k_q[IDX_BITS-1:0];
        if (pass_k_q != '0) begin
          if (found_q) begin
            sort_req_o.we    = 1'b1;
            sort_req_o.waddr = k_m2[IDX_BITS-1:0];
            sort_req_o.wdata = sort_rdata_i;
          end else if (cmp_rsp_i.eq) begin
            found_d = 1'b1;
          end
        end
        if (pass_k_q == n_q) begin
          pass_k_d = '0;
          n_d      = len_q - LEN_BITS'(1);
          state_d  = ST_INSERT;
        end else begin
          pass_k_d = pass_k_q + LEN_BITS'(1);
        end
      end
      ST_INSERT: begin
        cmp_req_o.a      = sort_rdata_i;
        cmp_req_o.b0     = amount_q;
        sort_req_o.re    = (pass_k_q < n_q);
        sort_req_o.raddr = pass_k_q[IDX_BITS-1:0];
        if (pass_k_q != '0) begin
          if (!placed_q) begin
            if (cmp_rsp_i.ge) begin
              sort_req_o.we    = 1'b1;
              sort_req_o.waddr = k_m1[IDX_BITS-1:0];
              sort_req_o.wdata = amount_q;
              carry_d          = sort_rdata_i;
              placed_d         = 1'b1;
            end
          end else begin
            sort_req_o.we    = 1'b1;
            sort_req_o.waddr = k_m1[IDX_BITS-1:0];
            sort_req_o.wdata = carry_q;
            carry_d          = sort_rdata_i;
          end
        end
        if (pass_k_q == n_q) begin
          state_d = ST_PLACE;
        end else begin
          pass_k_d = pass_k_q + LEN_BITS'(1);
        end
      end
      ST_PLACE: begin
        sort_req_o.we    = 1'b1;
        sort_req_o.waddr = n_q[IDX_BITS-1:0];
        sort_req_o.wdata = placed_q ? carry_q : amount_q;
        ring_req_o.we    = 1'b1;
        ring_req_o.waddr = ptr_q;
        ring_req_o.wdata = amount_q;
        ptr_d            = (ptr_inc >= len_q) ? '0 : ptr_inc[IDX_BITS-1:0];
        if (!ready_q) begin
          fill_d = fill_q + LEN_BITS'(1);
        end
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_notice_d = notice_q;
          out_count_d  = cnt_q;
          out_ready_d  = ready_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wlen_q       <= LEN_RESET;
      len_q        <= '0;
      fill_q       <= '0;
      ptr_q        <= '0;
      cnt_q        <= '0;
      amount_q     <= '0;
      ready_q      <= 1'b0;
      notice_q     <= 1'b0;
      med_lo_q     <= '0;
      pass_k_q     <= '0;
      n_q          <= '0;
      found_q      <= 1'b0;
      placed_q     <= 1'b0;
      carry_q      <= '0;
      out_valid_q  <= 1'b0;
      out_notice_q <= 1'b0;
      out_count_q  <= '0;
      out_ready_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      wlen_q       <= wlen_d;
      len_q        <= len_d;
      fill_q       <= fill_d;
      ptr_q        <= ptr_d;
      cnt_q        <= cnt_d;
      amount_q     <= amount_d;
      ready_q      <= ready_d;
      notice_q     <= notice_d;
      med_lo_q     <= med_lo_d;
      pass_k_q     <= pass_k_d;
      n_q          <= n_d;
      found_q      <= found_d;
      placed_q     <= placed_d;
      carry_q      <= carry_d;
      out_valid_q  <= out_valid_d;
      out_notice_q <= out_notice_d;
      out_count_q  <= out_count_d;
      out_ready_q  <= out_ready_d;
    end
  end

endmodule

### design/smsd_checker.sv
`include "sliding_median_spike_detector_top_defines.svh"

module smsd_checker import smsd_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_ready_o,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  notice_o,
  input logic [COUNT_BITS-1:0] notice_count_o,
  input logic                  window_ready_o
);

  `SMSD_ASSERT_NEXT(a_out_held, out_valid_o && !out_ready_i, out_valid_o, "result transaction dropped while stalled")
  `SMSD_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o, "second transaction taken while busy")
  `SMSD_ASSERT_SAME(a_notice_full, out_valid_o && notice_o, window_ready_o, "notice raised while the window fills")
  `SMSD_ASSERT_SAME(a_notice_count, out_valid_o && notice_o, notice_count_o != '0, "notice without a count")
  `SMSD_ASSERT_SAME(a_cfg_when_idle, in_ready_o, cfg_ready_o, "input open while configuration is closed")

endmodule

bind sliding_median_spike_detector_top smsd_checker u_smsd_checker (.*);

### tb/tb_sliding_median_spike_detector_top.sv
module tb_sliding_median_spike_detector_top import smsd_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 6000;
  localparam int unsigned DRAIN_CYCLES   = 2 * WINDOW_MAX + 16;

  typedef struct packed {
    logic [VALUE_BITS-1:0] amount;
    logic                  start_new;
  } sample_t;

  typedef struct packed {
    logic                  notice;
    logic [COUNT_BITS-1:0] count;
    logic                  ready;
  } verdict_t;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_BITS-1:0]   window_len_i   = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [VALUE_BITS-1:0] amount_i       = '0;
  logic                  start_new_i    = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic                  notice_o;
  logic [COUNT_BITS-1:0] notice_count_o;
  logic                  window_ready_o;

  sliding_median_spike_detector_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .window_len_i   (window_len_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .amount_i       (amount_i),
    .start_new_i    (start_new_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .notice_o       (notice_o),
    .notice_count_o (notice_count_o),
    .window_ready_o (window_ready_o)
  );

  sample_t     pending_q[$];
  verdict_t    verdicts_q[$];
  verdict_t    want;
  idle_mode_e  idle_mode   = IDLE_NONE;
  int unsigned mismatches  = 0;
  int unsigned quiet       = 0;
  int unsigned hold_left   = 0;
  logic        hold_req    = 1'b0;
  logic        hold_taken  = 1'b0;

  logic [VALUE_BITS-1:0] med_sorted   [WINDOW_MAX];
  logic [VALUE_BITS-1:0] arrival_hist [WINDOW_MAX];
  int unsigned           oldest_slot = 0;
  int unsigned           held        = 0;
  logic [COUNT_BITS-1:0] spike_total = '0;
  logic [CFG_BITS-1:0]   cur_len     = LEN_RESET;

  function automatic void drop_value(logic [VALUE_BITS-1:0] val, int unsigned n);
    int unsigned p;
    int unsigned i;
    bit          found;
    p = n - 1;
    found = 1'b0;
    for (i = 0; i < n; i++) begin
      if (!found && med_sorted[i] == val) begin
        p = i;
        found = 1'b1;
      end
    end
    for (i = p; i + 1 < n; i++) begin
      med_sorted[i] = med_sorted[i + 1];
    end
  endfunction

  function automatic void place_value(logic [VALUE_BITS-1:0] val, int unsigned n);
    int unsigned p;
    int unsigned i;
    bit          found;
    p = n;
    found = 1'b0;
    for (i = 0; i < n; i++) begin
      if (!found && med_sorted[i] >= val) begin
        p = i;
        found = 1'b1;
      end
    end
    for (i = n; i > p; i--) begin
      med_sorted[i] = med_sorted[i - 1];
    end
    if (p < WINDOW_MAX) begin
      med_sorted[p] = val;
    end
  endfunction

  function automatic verdict_t predict_spike(logic [VALUE_BITS-1:0] amount, logic start_new);
    int unsigned         len;
    int unsigned         half;
    logic [VALUE_BITS:0] dmed;
    verdict_t            v;
    v = '0;
    if (start_new) begin
      held = 0;
      oldest_slot = 0;
      spike_total = '0;
    end
    if (cur_len == 0) begin
      len = 1;
    end else if (cur_len > WINDOW_MAX) begin
      len = WINDOW_MAX;
    end else begin
      len = cur_len;
    end
    if (held > len) held = len;
    if (oldest_slot >= len) oldest_slot = 0;
    v.ready = (held == len);
    if (v.ready) begin
      half = len >> 1;
      if (len % 2 == 1) begin
        dmed = {med_sorted[half], 1'b0};
      end else begin
        dmed = {1'b0, med_sorted[half]} + {1'b0, med_sorted[half - 1]};
      end
      v.notice = ({1'b0, amount} >= dmed);
      if (v.notice && spike_total != COUNT_MAX) begin
        spike_total = spike_total + COUNT_BITS'(1);
      end
      drop_value(arrival_hist[oldest_slot], len);
      place_value(amount, len - 1);
      arrival_hist[oldest_slot] = amount;
    end else begin
      place_value(amount, held);
      arrival_hist[oldest_slot] = amount;
      held++;
    end
    oldest_slot++;
    if (oldest_slot >= len) oldest_slot = 0;
    v.count = spike_total;
    return v;
  endfunction

  function automatic bit send_gap();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 72;
      IDLE_BOTH: return $urandom_range(99) < 27;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit recv_stall();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(99) < 72;
      IDLE_BOTH: return $urandom_range(99) < 27;
      default:   return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(string why, verdict_t exp_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch (%s) at %0t: expected notice=%0d count=%0d ready=%0d,",
               why, $time, exp_v.notice, exp_v.count, exp_v.ready);
      $display("  got notice=%0d count=%0d ready=%0d",
               notice_o, notice_count_o, window_ready_o);
    end
  endtask

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      amount_i    <= '0;
      start_new_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        verdicts_q.insert(verdicts_q.size(), predict_spike(amount_i, start_new_i));
      end
      if (pending_q.size() != 0 && !send_gap()) begin
        in_valid_i  <= 1'b1;
        amount_i    <= pending_q[0].amount;
        start_new_i <= pending_q[0].start_new;
        pending_q.delete(0);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (verdicts_q.size() == 0) begin
          report_mismatch("no result expected", '0);
        end else begin
          want = verdicts_q.pop_front();
          if (notice_o !== want.notice || notice_count_o !== want.count ||
              window_ready_o !== want.ready) begin
            report_mismatch("field differs", want);
          end
        end
      end
      out_ready_i <= (hold_left == 0) && !recv_stall();
    end
  end

  // The long receiver hold-off is timed here, apart from the stimulus.
  always @(posedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic queue_sample(int unsigned amount, bit start_new);
    sample_t s;
    s.amount    = VALUE_BITS'(amount);
    s.start_new = start_new;
    pending_q.insert(pending_q.size(), s);
  endtask

  task automatic queue_random(int unsigned n);
    int unsigned base;
    int unsigned pick;
    int unsigned k;
    sample_t     s;
    base = $urandom_range(2000, 20);
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        s.amount = VALUE_BITS'($urandom_range(base + base / 2, base));
      end else if (pick < 60) begin
        s.amount = VALUE_BITS'($urandom_range(4 * base, 2 * base));
      end else if (pick < 72) begin
        s.amount = VALUE_BITS'(base);
      end else if (pick < 77) begin
        s.amount = '0;
      end else if (pick < 82) begin
        s.amount = '1;
      end else begin
        s.amount = VALUE_BITS'($urandom());
      end
      s.start_new = ($urandom_range(99) < 3);
      pending_q.insert(pending_q.size(), s);
    end
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_valid_i || verdicts_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // A length write empties the window but keeps the notice count.
  task automatic write_len(int unsigned len);
    @(posedge clk_i);
    cfg_valid_i  <= 1'b1;
    window_len_i <= CFG_BITS'(len);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_len     = CFG_BITS'(len);
    held        = 0;
    oldest_slot = 0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_mode = IDLE_NONE;
    queue_sample(10, 1'b1);
    queue_sample(20, 1'b0);
    queue_sample(30, 1'b0);
    queue_sample(40, 1'b0);
    queue_sample(50, 1'b0);
    queue_sample(60, 1'b0);
    queue_sample(79, 1'b0);
    queue_sample(65535, 1'b0);
    queue_sample(0, 1'b0);
    repeat (5) queue_sample(7, 1'b0);
    queue_sample(14, 1'b0);
    queue_sample(13, 1'b0);
    queue_sample(65535, 1'b0);
    queue_sample(65535, 1'b1);
    repeat (4) queue_sample(0, 1'b0);
    queue_sample(0, 1'b0);
    drain();

    write_len(1);
    idle_mode = IDLE_SEND;
    queue_random(20);
    drain();

    write_len(0);
    idle_mode = IDLE_RECV;
    queue_random(15);
    drain();

    write_len(2);
    idle_mode = IDLE_BOTH;
    queue_random(25);
    drain();

    write_len(3);
    idle_mode = IDLE_NONE;
    hold_req <= 1'b1;
    queue_random(30);
    drain();

    write_len(8);
    idle_mode = IDLE_SEND;
    queue_random(12);
    drain();
    queue_random(13);
    drain();

    write_len(4);
    idle_mode = IDLE_RECV;
    queue_random(20);
    drain();

    write_len(6);
    idle_mode = IDLE_BOTH;
    queue_random(25);
    drain();

    write_len(256);
    idle_mode = IDLE_NONE;
    queue_random(8);
    drain();

    write_len(257);
    queue_random(262);
    drain();

    write_len(511);
    idle_mode = IDLE_BOTH;
    queue_random(8);
    drain();

    write_len(5);
    idle_mode = IDLE_NONE;
    queue_random(20);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && verdicts_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/smsd_pkg.sv
design/smsd_ram.sv
design/smsd_cmp.sv
design/smsd_ctrl.sv
design/sliding_median_spike_detector_top.sv
design/smsd_checker.sv
tb/tb_sliding_median_spike_detector_top.sv
